// ----- sv/scw_pkg.sv -----
`timescale 1ns / 1ps

package scw_pkg;

  // Operation codes carried by a request (the unused code behaves as a poll).
  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_REFRESH = 2'd1,
    OP_POLL    = 2'd2,
    OP_SPARE   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_ALIVE         = 4'd0,
    ST_BACKWARD      = 4'd1,
    ST_BAD_SESSION   = 4'd2,
    ST_NOT_NEW       = 4'd3,
    ST_NO_SESSION    = 4'd4,
    ST_MISMATCH      = 4'd5,
    ST_BAD_SEQ       = 4'd6,
    ST_BAD_REQ       = 4'd7,
    ST_BAD_VALIDITY  = 4'd8,
    ST_NEEDS_SESSION = 4'd9,
    ST_AMBIGUOUS     = 4'd10,
    ST_DUPLICATE     = 4'd11,
    ST_STALE_SEQ     = 4'd12,
    ST_STALE_REQ     = 4'd13,
    ST_SAFE          = 4'd14,
    ST_EXPIRED       = 4'd15
  } status_t;

  // Configuration register indexes (byte address is eight times the index).
  typedef enum logic [0:0] {
    REG_TIMEOUT  = 1'b0,
    REG_VALIDITY = 1'b1
  } reg_idx_t;

  localparam int unsigned  ADDR_W           = 4;
  localparam logic [63:0]  TIMEOUT_RESET    = 64'd100000000;
  localparam logic [15:0]  VALIDITY_RESET   = 16'd100;
  localparam logic [31:0]  SERIAL_HALF      = 32'h8000_0000;

  // Serial-number comparison result of a candidate against the stored value.
  typedef struct packed {
    logic same;
    logic ambig;
    logic newer;
  } serial_ord_t;

  function automatic serial_ord_t serial_order(input logic [31:0] cand,
                                               input logic [31:0] cur);
    logic [31:0] d;
    serial_ord_t o;
    d       = cand - cur;
    o.same  = (d == 32'd0);
    o.ambig = (d == SERIAL_HALF);
    o.newer = (d != 32'd0) && !d[31];
    return o;
  endfunction

endpackage

// ----- sv/session_command_watchdog_core.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------------
// in_       | input     | in_valid / in_stall | op, session, sequence, request, validity,
//           |           |                     | time_ns
// out_      | output    | out_valid/out_stall | status, safe_flag
// APB       | input     | psel/penable/pready | timeout at 0x0, validity at 0x8
//
// A request is captured in an input register, then judged, and its state
// update and result are written together into the result register; one request
// per cycle is sustained while the result side does not stall.
// The throughput is set by the single state-update step (64-bit time compare
// and the 64-bit elapsed-time subtract and compare against the timeout).
// rst_n is synchronous; it clears the session state, both valid flags and
// restores the register reset values.
// A stalled result holds the output register, and the input register then
// stalls the input channel unless it is empty.
module session_command_watchdog_core
  import scw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_session_number,
  input  logic [31:0]         in_sequence_number,
  input  logic [31:0]         in_request_number,
  input  logic [15:0]         in_validity_value,
  input  logic [63:0]         in_time_ns,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_status,
  output logic                out_safe_flag,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  // Configuration registers.
  logic [63:0] timeout_r;
  logic [15:0] req_validity_r;

  // Input register.
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [31:0] s1_sid_r;
  logic [31:0] s1_seq_r;
  logic [31:0] s1_req_r;
  logic [15:0] s1_val_r;
  logic [63:0] s1_time_r;

  // Result register.
  logic        out_valid_r;
  status_t     out_status_r;
  logic        out_safe_r;

  // Watchdog state.
  logic        time_seen_r,      time_seen_nxt;
  logic [63:0] last_time_r,      last_time_nxt;
  logic        session_open_r,   session_open_nxt;
  logic [31:0] active_session_r, active_session_nxt;
  logic        prev_valid_r,     prev_valid_nxt;
  logic [31:0] prev_session_r,   prev_session_nxt;
  logic        refresh_seen_r,   refresh_seen_nxt;
  logic [63:0] refresh_time_r,   refresh_time_nxt;
  logic [31:0] last_seq_r,       last_seq_nxt;
  logic [31:0] last_req_r,       last_req_nxt;
  logic        safe_hold_r,      safe_hold_nxt;
  logic        needs_session_r,  needs_session_nxt;
  status_t     status_nxt;

  logic        s2_ready;
  logic        advance;
  logic        time_ok;
  logic [63:0] elapsed;
  serial_ord_t seq_ord;
  serial_ord_t req_ord;
  reg_idx_t    wr_idx;

  // Handshake: the result register frees when empty or taken.
  assign s2_ready = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_safe_flag = out_safe_r;

  // Configuration port: always ready, read mux on the register index.
  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[3]);

  always_comb begin
    case (wr_idx)
      REG_TIMEOUT:  prdata = timeout_r;
      REG_VALIDITY: prdata = {48'd0, req_validity_r};
      default:      prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= TIMEOUT_RESET;
      req_validity_r <= VALIDITY_RESET;
    end else if (psel && penable && pwrite) begin
      case (wr_idx)
        REG_TIMEOUT:  timeout_r      <= pwdata;
        REG_VALIDITY: req_validity_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= op_t'(in_op);
      s1_sid_r  <= in_session_number;
      s1_seq_r  <= in_sequence_number;
      s1_req_r  <= in_request_number;
      s1_val_r  <= in_validity_value;
      s1_time_r <= in_time_ns;
    end
  end

  // Shared comparisons used by the decision logic.
  assign time_ok = !(time_seen_r && (s1_time_r < last_time_r));
  assign elapsed = s1_time_r - refresh_time_r;
  assign seq_ord = serial_order(s1_seq_r, last_seq_r);
  assign req_ord = serial_order(s1_req_r, last_req_r);

  // Decision logic: status and next state for the request in the input register.
  always_comb begin
    time_seen_nxt      = time_seen_r;
    last_time_nxt      = last_time_r;
    session_open_nxt   = session_open_r;
    active_session_nxt = active_session_r;
    prev_valid_nxt     = prev_valid_r;
    prev_session_nxt   = prev_session_r;
    refresh_seen_nxt   = refresh_seen_r;
    refresh_time_nxt   = refresh_time_r;
    last_seq_nxt       = last_seq_r;
    last_req_nxt       = last_req_r;
    safe_hold_nxt      = safe_hold_r;
    needs_session_nxt  = needs_session_r;
    status_nxt         = ST_ALIVE;

    if (s1_op_r == OP_BEGIN && s1_sid_r == 32'd0) begin
      // A zero session id on begin is rejected before the time check.
      status_nxt = ST_BAD_SESSION;
    end else if (!time_ok) begin
      status_nxt    = ST_BACKWARD;
      safe_hold_nxt = 1'b1;
      if (refresh_seen_r) begin
        needs_session_nxt = 1'b1;
      end
    end else begin
      time_seen_nxt = 1'b1;
      last_time_nxt = s1_time_r;
      case (s1_op_r)
        OP_BEGIN: begin
          if ((session_open_r && active_session_r == s1_sid_r) ||
              (prev_valid_r && prev_session_r == s1_sid_r)) begin
            status_nxt = ST_NOT_NEW;
          end else begin
            if (session_open_r) begin
              prev_session_nxt = active_session_r;
              prev_valid_nxt   = 1'b1;
            end
            active_session_nxt = s1_sid_r;
            refresh_time_nxt   = 64'd0;
            last_seq_nxt       = 32'd0;
            last_req_nxt       = 32'd0;
            session_open_nxt   = 1'b1;
            refresh_seen_nxt   = 1'b0;
            safe_hold_nxt      = 1'b1;
            needs_session_nxt  = 1'b0;
          end
        end
        OP_REFRESH: begin
          if (s1_sid_r == 32'd0) begin
            status_nxt = ST_BAD_SESSION;
          end else if (!session_open_r) begin
            status_nxt = ST_NO_SESSION;
          end else if (s1_sid_r != active_session_r) begin
            status_nxt = ST_MISMATCH;
          end else if (s1_seq_r == 32'd0) begin
            status_nxt = ST_BAD_SEQ;
          end else if (s1_req_r == 32'd0) begin
            status_nxt = ST_BAD_REQ;
          end else if (s1_val_r != req_validity_r) begin
            status_nxt = ST_BAD_VALIDITY;
          end else if (needs_session_r) begin
            status_nxt = ST_NEEDS_SESSION;
          end else if (refresh_seen_r && (seq_ord.ambig || req_ord.ambig)) begin
            status_nxt = ST_AMBIGUOUS;
          end else if (refresh_seen_r && seq_ord.same && req_ord.same) begin
            status_nxt = ST_DUPLICATE;
          end else if (refresh_seen_r && !seq_ord.newer) begin
            status_nxt = ST_STALE_SEQ;
          end else if (refresh_seen_r && !req_ord.newer) begin
            status_nxt = ST_STALE_REQ;
          end else begin
            last_seq_nxt      = s1_seq_r;
            last_req_nxt      = s1_req_r;
            refresh_time_nxt  = s1_time_r;
            refresh_seen_nxt  = 1'b1;
            safe_hold_nxt     = 1'b0;
            needs_session_nxt = 1'b0;
          end
        end
        default: begin
          // Poll, and the spare code which behaves the same.
          if (!session_open_r || !refresh_seen_r) begin
            safe_hold_nxt = 1'b1;
            status_nxt    = ST_SAFE;
          end else if (safe_hold_r) begin
            status_nxt = ST_EXPIRED;
          end else if (elapsed >= timeout_r) begin
            safe_hold_nxt     = 1'b1;
            needs_session_nxt = 1'b1;
            status_nxt        = ST_EXPIRED;
          end
        end
      endcase
    end
  end

  // State and result registers, written as the request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_seen_r      <= 1'b0;
      last_time_r      <= 64'd0;
      session_open_r   <= 1'b0;
      active_session_r <= 32'd0;
      prev_valid_r     <= 1'b0;
      prev_session_r   <= 32'd0;
      refresh_seen_r   <= 1'b0;
      refresh_time_r   <= 64'd0;
      last_seq_r       <= 32'd0;
      last_req_r       <= 32'd0;
      safe_hold_r      <= 1'b1;
      needs_session_r  <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        time_seen_r      <= time_seen_nxt;
        last_time_r      <= last_time_nxt;
        session_open_r   <= session_open_nxt;
        active_session_r <= active_session_nxt;
        prev_valid_r     <= prev_valid_nxt;
        prev_session_r   <= prev_session_nxt;
        refresh_seen_r   <= refresh_seen_nxt;
        refresh_time_r   <= refresh_time_nxt;
        last_seq_r       <= last_seq_nxt;
        last_req_r       <= last_req_nxt;
        safe_hold_r      <= safe_hold_nxt;
        needs_session_r  <= needs_session_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_safe_r   <= safe_hold_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The output must be live only after an accepted refresh of an open session.
  a_live_needs_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    !safe_hold_r |-> (session_open_r && refresh_seen_r))
    else $error("safe hold clear without an open, refreshed session");

  // A forced new session always keeps the output safe.
  a_needs_implies_safe: assert property (@(posedge clk) disable iff (!rst_n)
    needs_session_r |-> safe_hold_r)
    else $error("new session required while the safe hold is clear");

  // A session can only be open once a timestamp has been taken.
  a_open_after_time: assert property (@(posedge clk) disable iff (!rst_n)
    session_open_r |-> time_seen_r)
    else $error("session open before any accepted time");

  // A request leaving the input register always lands in the result register.
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("request lost between input and result registers");

  // The result flag mirrors the stored safe-hold state.
  a_flag_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_safe_r == safe_hold_r))
    else $error("result safe flag differs from the safe hold");
`endif

endmodule

// ----- tb/scw_tb_pkg.sv -----
`timescale 1ns / 1ps

package scw_tb_pkg;

  import scw_pkg::*;

  // One request as offered on the input channel.
  typedef struct {
    op_t         op;
    logic [31:0] sess_num;
    logic [31:0] seq_num;
    logic [31:0] req_num;
    logic [15:0] validity;
    logic [63:0] stamp_ns;
  } watch_request_t;

  // One result as it should leave the block.
  typedef struct {
    status_t status;
    logic    safe_flag;
  } watch_result_t;

  typedef enum {REL_OLDER, REL_SAME, REL_NEWER, REL_AMBIG} serial_rel_t;

  // Tracks the watchdog state, predicts the result of every accepted request
  // and compares the results leaving the block against those predictions.
  class watchdog_scoreboard;
    logic [63:0] timeout_ns;
    logic [15:0] required_validity;

    bit          time_seen;
    logic [63:0] last_stamp;
    bit          session_open;
    logic [31:0] active_session;
    bit          previous_valid;
    logic [31:0] previous_session;
    bit          refresh_seen;
    logic [63:0] refresh_stamp;
    logic [31:0] last_seq;
    logic [31:0] last_req;
    bit          safe_hold;
    bit          needs_new_session;

    watch_result_t expected_results[$];
    int            failures;

    function new();
      timeout_ns        = TIMEOUT_RESET;
      required_validity = VALIDITY_RESET;
      time_seen         = 1'b0;
      last_stamp        = '0;
      session_open      = 1'b0;
      active_session    = '0;
      previous_valid    = 1'b0;
      previous_session  = '0;
      refresh_seen      = 1'b0;
      refresh_stamp     = '0;
      last_seq          = '0;
      last_req          = '0;
      safe_hold         = 1'b1;
      needs_new_session = 1'b0;
      failures          = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [63:0] value);
      if (idx == REG_TIMEOUT) begin
        timeout_ns = value;
      end else begin
        required_validity = value[15:0];
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // A step backwards in time forces the safe state and, once a refresh has
    // been seen, a new session; the last good time is then kept.
    function bit stamp_accepted(logic [63:0] stamp);
      if (time_seen && stamp < last_stamp) begin
        safe_hold = 1'b1;
        if (refresh_seen) needs_new_session = 1'b1;
        return 1'b0;
      end
      last_stamp = stamp;
      time_seen  = 1'b1;
      return 1'b1;
    endfunction

    // Serial-number order in 32-bit arithmetic; half the range is ambiguous.
    function serial_rel_t serial_rel(logic [31:0] cand, logic [31:0] cur);
      logic [31:0] d;
      d = cand - cur;
      if (d == 32'd0) return REL_SAME;
      if (d == SERIAL_HALF) return REL_AMBIG;
      if (!d[31]) return REL_NEWER;
      return REL_OLDER;
    endfunction

    function void note_request(watch_request_t r);
      status_t       st;
      status_t       id_st;
      serial_rel_t   so;
      serial_rel_t   ro;
      watch_result_t res;

      // Verdict of the sequence and request identity check.
      so = serial_rel(r.seq_num, last_seq);
      ro = serial_rel(r.req_num, last_req);
      if (so == REL_AMBIG || ro == REL_AMBIG) id_st = ST_AMBIGUOUS;
      else if (so == REL_SAME && ro == REL_SAME) id_st = ST_DUPLICATE;
      else if (so != REL_NEWER) id_st = ST_STALE_SEQ;
      else if (ro != REL_NEWER) id_st = ST_STALE_REQ;
      else id_st = ST_ALIVE;

      // A begin with a zero session is turned away before the time check.
      if (r.op == OP_BEGIN && r.sess_num == 32'd0) begin
        st = ST_BAD_SESSION;
      end else if (!stamp_accepted(r.stamp_ns)) begin
        st = ST_BACKWARD;
      end else if (r.op == OP_BEGIN) begin
        if ((session_open && active_session == r.sess_num) ||
            (previous_valid && previous_session == r.sess_num)) begin
          st = ST_NOT_NEW;
        end else begin
          if (session_open) begin
            previous_session = active_session;
            previous_valid   = 1'b1;
          end
          active_session    = r.sess_num;
          refresh_stamp     = '0;
          last_seq          = '0;
          last_req          = '0;
          session_open      = 1'b1;
          refresh_seen      = 1'b0;
          safe_hold         = 1'b1;
          needs_new_session = 1'b0;
          st                = ST_ALIVE;
        end
      end else if (r.op == OP_REFRESH) begin
        if (r.sess_num == 32'd0) st = ST_BAD_SESSION;
        else if (!session_open) st = ST_NO_SESSION;
        else if (r.sess_num != active_session) st = ST_MISMATCH;
        else if (r.seq_num == 32'd0) st = ST_BAD_SEQ;
        else if (r.req_num == 32'd0) st = ST_BAD_REQ;
        else if (r.validity != required_validity) st = ST_BAD_VALIDITY;
        else if (needs_new_session) st = ST_NEEDS_SESSION;
        else if (refresh_seen && id_st != ST_ALIVE) st = id_st;
        else begin
          last_seq          = r.seq_num;
          last_req          = r.req_num;
          refresh_stamp     = r.stamp_ns;
          refresh_seen      = 1'b1;
          safe_hold         = 1'b0;
          needs_new_session = 1'b0;
          st                = ST_ALIVE;
        end
      end else begin
        // Poll; the spare operation code behaves the same way.
        if (!session_open || !refresh_seen) begin
          safe_hold = 1'b1;
          st        = ST_SAFE;
        end else if (safe_hold) begin
          st = ST_EXPIRED;
        end else if (r.stamp_ns - refresh_stamp >= timeout_ns) begin
          safe_hold         = 1'b1;
          needs_new_session = 1'b1;
          st                = ST_EXPIRED;
        end else begin
          st = ST_ALIVE;
        end
      end

      res.status    = st;
      res.safe_flag = safe_hold;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [3:0] status, logic safe_flag);
      watch_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: status %0d safe_flag %0b",
               status, safe_flag);
        failures++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d (%s), got %0d", exp_res.status,
               exp_res.status.name(), status);
        failures++;
      end
      if (safe_flag !== exp_res.safe_flag) begin
        $error("safe_flag: expected %0b, got %0b", exp_res.safe_flag, safe_flag);
        failures++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_session_command_watchdog_core.sv -----
`timescale 1ns / 1ps

module tb_session_command_watchdog_core;

  import scw_pkg::*;
  import scw_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op = '0;
  logic [31:0]       in_session_number = '0;
  logic [31:0]       in_sequence_number = '0;
  logic [31:0]       in_request_number = '0;
  logic [15:0]       in_validity_value = '0;
  logic [63:0]       in_time_ns = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_status;
  logic              out_safe_flag;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  watchdog_scoreboard sb = new();

  // Shared pacing controls.
  bit calm = 1'b0;
  bit hold_off_request = 1'b0;

  // Generator view of the session, used to build well-formed refreshes.
  logic [63:0] gen_time = '0;
  logic [31:0] gen_sid = '0;
  logic [31:0] prev_sid = '0;
  logic [31:0] gen_seq = '0;
  logic [31:0] gen_req = '0;
  logic [15:0] validity_now = VALIDITY_RESET;
  int unsigned max_step = 50;
  bit          high_time = 1'b0;

  int unsigned quiet_cycles = 0;

  session_command_watchdog_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_session_number  (in_session_number),
    .in_sequence_number (in_sequence_number),
    .in_request_number  (in_request_number),
    .in_validity_value  (in_validity_value),
    .in_time_ns         (in_time_ns),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_safe_flag      (out_safe_flag),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, with one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_safe_flag);
  end

  // The run ends if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one request and waits until the block takes it.
  task automatic send_request(watch_request_t r);
    in_op              <= r.op;
    in_session_number  <= r.sess_num;
    in_sequence_number <= r.seq_num;
    in_request_number  <= r.req_num;
    in_validity_value  <= r.validity;
    in_time_ns         <= r.stamp_ns;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic direct(op_t op, logic [31:0] sid, logic [31:0] seq, logic [31:0] req,
                        logic [15:0] val, logic [63:0] stamp);
    watch_request_t r;
    r.op         = op;
    r.sess_num   = sid;
    r.seq_num    = seq;
    r.req_num    = req;
    r.validity   = val;
    r.stamp_ns   = stamp;
    send_request(r);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [63:0] value);
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers only change once the block has gone quiet.
  task automatic reconfigure(logic [63:0] timeout, logic [15:0] validity,
                             int unsigned step);
    drain_results();
    repeat (4) @(posedge clk);
    write_register(REG_TIMEOUT, timeout);
    write_register(REG_VALIDITY, {48'd0, validity});
    validity_now = validity;
    max_step     = step;
  endtask

  // Builds one random request, mostly well-formed session traffic.
  task automatic make_request(output watch_request_t r);
    int unsigned pick;
    logic [63:0] dt;
    pick = $urandom_range(99);
    dt   = ($urandom_range(99) < 3) ? 64'(max_step) * 8 : 64'($urandom_range(max_step));
    if (!high_time) gen_time = gen_time + dt;

    r.op         = OP_POLL;
    r.sess_num   = $urandom;
    r.seq_num    = $urandom;
    r.req_num    = $urandom;
    r.validity   = 16'($urandom);
    r.stamp_ns   = gen_time;

    if (pick < 10) begin
      // Fresh session; the first refresh may carry any nonzero numbers.
      prev_sid = gen_sid;
      gen_sid  = $urandom;
      if (gen_sid == 32'd0) gen_sid = 32'd1;
      gen_seq      = $urandom;
      gen_req      = $urandom;
      r.op         = OP_BEGIN;
      r.sess_num   = gen_sid;
    end else if (pick < 13) begin
      r.op = OP_BEGIN;
      case ($urandom_range(2))
        0: r.sess_num = gen_sid;
        1: r.sess_num = prev_sid;
        default: r.sess_num = 32'd0;
      endcase
    end else if (pick < 55) begin
      gen_seq      = gen_seq + $urandom_range(1, 3);
      gen_req      = gen_req + $urandom_range(1, 3);
      r.op         = OP_REFRESH;
      r.sess_num   = gen_sid;
      r.seq_num    = gen_seq;
      r.req_num    = gen_req;
      r.validity   = validity_now;
    end else if (pick < 63) begin
      // Identity corners: duplicate, ambiguous, stale.
      r.op         = OP_REFRESH;
      r.sess_num   = gen_sid;
      r.validity   = validity_now;
      r.seq_num    = gen_seq + 1;
      r.req_num    = gen_req + 1;
      case ($urandom_range(4))
        0: begin
          r.seq_num = gen_seq;
          r.req_num = gen_req;
        end
        1: r.seq_num = gen_seq + SERIAL_HALF;
        2: r.req_num = gen_req + SERIAL_HALF;
        3: r.seq_num = gen_seq - $urandom_range(5);
        default: r.req_num = gen_req - $urandom_range(5);
      endcase
    end else if (pick < 70) begin
      r.op         = OP_REFRESH;
      r.sess_num   = gen_sid;
      r.seq_num    = gen_seq + 1;
      r.req_num    = gen_req + 1;
      r.validity   = validity_now;
      case ($urandom_range(4))
        0: r.sess_num = 32'd0;
        1: r.sess_num = $urandom;
        2: r.seq_num = 32'd0;
        3: r.req_num = 32'd0;
        default: r.validity = ~validity_now;
      endcase
    end else if (pick < 90) begin
      r.op = ($urandom_range(9) == 0) ? OP_SPARE : OP_POLL;
    end else if (pick < 95) begin
      // Clock stepping backwards.
      r.op       = op_t'($urandom_range(3));
      r.stamp_ns = (gen_time > dt) ? gen_time - dt - 1 : 64'd0;
    end else begin
      r.op = op_t'($urandom_range(3));
    end

    // Late phase: times spread over the whole 64-bit range.
    if (high_time && $urandom_range(1) == 1) begin
      r.stamp_ns = {$urandom, $urandom};
      if (r.stamp_ns > gen_time) gen_time = r.stamp_ns;
    end
  endtask

  task automatic run_random(int count);
    watch_request_t r;
    for (int i = 0; i < count; i++) begin
      // Each idle cycle is drawn on its own, so about one cycle in seven is empty.
      while (!calm && $urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      make_request(r);
      send_request(r);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the status codes at the reset settings.
    direct(OP_POLL,    32'd0, 32'd0, 32'd0, 16'd0, 64'd0);
    direct(OP_REFRESH, 32'd5, 32'd1, 32'd1, 16'd100, 64'd10);
    direct(OP_BEGIN,   32'd0, 32'd0, 32'd0, 16'd0, 64'd5);
    direct(OP_BEGIN,   32'd5, 32'd0, 32'd0, 16'd0, 64'd20);
    direct(OP_BEGIN,   32'd5, 32'd0, 32'd0, 16'd0, 64'd20);
    direct(OP_REFRESH, 32'd0, 32'd1, 32'd1, 16'd100, 64'd21);
    direct(OP_REFRESH, 32'hFFFF_FFFF, 32'd1, 32'd1, 16'd100, 64'd22);
    direct(OP_REFRESH, 32'd5, 32'd0, 32'd1, 16'd100, 64'd23);
    direct(OP_REFRESH, 32'd5, 32'd1, 32'd0, 16'd100, 64'd24);
    direct(OP_REFRESH, 32'd5, 32'd1, 32'd1, 16'hFFFF, 64'd25);
    direct(OP_POLL,    32'd0, 32'd0, 32'd0, 16'd0, 64'd30);
    direct(OP_REFRESH, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 64'd40);
    direct(OP_POLL,    32'd0, 32'd0, 32'd0, 16'd0, 64'd50);
    direct(OP_REFRESH, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 64'd51);
    direct(OP_REFRESH, 32'd5, 32'h7FFF_FFFF, 32'd1, 16'd100, 64'd52);
    direct(OP_REFRESH, 32'd5, 32'hFFFF_FFFE, 32'd1, 16'd100, 64'd53);
    direct(OP_REFRESH, 32'd5, 32'd1, 32'hFFFF_FFFF, 16'd100, 64'd54);
    direct(OP_REFRESH, 32'd5, 32'd1, 32'd1, 16'd100, 64'd60);
    // Poll exactly at the timeout, then again while safe is pending.
    direct(OP_SPARE,   32'd0, 32'd0, 32'd0, 16'd0, 64'd100000060);
    direct(OP_POLL,    32'd0, 32'd0, 32'd0, 16'd0, 64'd100000061);
    direct(OP_REFRESH, 32'd5, 32'd2, 32'd2, 16'd100, 64'd100000062);
    direct(OP_POLL,    32'd0, 32'd0, 32'd0, 16'd0, 64'd10);
    direct(OP_BEGIN,   32'd6, 32'd0, 32'd0, 16'd0, 64'd100000070);
    direct(OP_BEGIN,   32'd5, 32'd0, 32'd0, 16'd0, 64'd100000071);
    gen_time = 64'd100000100;
    gen_sid  = 32'd6;
    prev_sid = 32'd5;

    // Zero timeout: every checked poll expires.
    reconfigure(64'd0, 16'd0, 50);
    run_random(150);

    reconfigure(64'd1, 16'hFFFF, 3);
    run_random(200);

    // Busy phase: a stretch with no idling and one long result hold-off.
    reconfigure(64'd1000, 16'($urandom), 400);
    run_random(200);
    calm = 1'b1;
    run_random(250);
    calm = 1'b0;
    hold_off_request = 1'b1;
    run_random(250);

    reconfigure(64'hFFFF_FFFF_FFFF_FFFF, 16'd100, 100000);
    run_random(200);

    // The sender waits for every result once in the middle of this phase.
    reconfigure(64'($urandom_range(200, 5000)), 16'($urandom), 2000);
    run_random(300);
    drain_results();
    run_random(350);

    reconfigure({$urandom, $urandom}, 16'($urandom), 1000);
    high_time = 1'b1;
    run_random(100);

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
